@@ rtl/seglcd_pkg.sv @@
package seglcd_pkg;

    // segment memory and cell geometry
    localparam int SEG_BYTES   = 40;
    localparam int ADDR_W      = 6;
    localparam int CELLS       = 6;
    localparam int FRAC_DIGITS = 3;
    localparam int FRAC_W      = 2;
    localparam int VALUE_W     = 16;
    localparam int RADIX_W     = 6;
    localparam int DIG_DEPTH   = 16;
    localparam int DIG_CNT_W   = 5;
    localparam int DIG_IDX_W   = 4;
    localparam int DIV_CNT_W   = 5;

    // position mod CELLS by reciprocal multiply, exact for 8-bit positions
    localparam logic [15:0] CELL_RECIP    = 16'd171;
    localparam int          CELL_RECIP_SH = 10;

    // tens digit by reciprocal multiply, exact below 100
    localparam logic [14:0] TEN_RECIP    = 15'd205;
    localparam int          TEN_RECIP_SH = 11;

    localparam logic [ADDR_W-1:0] DOT_BYTE       = 6'd14;
    localparam logic [7:0]        DOT_MASK       = 8'h81;
    localparam logic [7:0]        FONT_BASE      = 8'd46;
    localparam logic [7:0]        CODE_ZERO      = 8'd48;
    localparam logic [7:0]        CODE_ALPHA     = 8'd55;
    localparam logic [7:0]        CODE_UNDERLINE = 8'd95;
    localparam logic [7:0]        FLASH_NONE     = 8'hFF;
    localparam int                FLASH_BIT      = 2;
    localparam logic [7:0]        FIXED_INT_POS  = 8'd2;
    localparam logic [7:0]        FIXED_FRAC_POS = 8'd3;
    localparam logic [6:0]        SMALL_MAX      = 7'd99;

    // register map
    localparam int   CFG_ADDR_W = 3;
    localparam logic REG_FLASH  = 1'b0;

    // operation codes
    localparam logic [2:0] OP_CHAR   = 3'd0;
    localparam logic [2:0] OP_NUMBER = 3'd1;
    localparam logic [2:0] OP_FIXED  = 3'd2;
    localparam logic [2:0] OP_SMALL  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CHAR_START,
        S_CHAR_RD,
        S_CHAR_WR,
        S_DOT_RD,
        S_DOT_WR,
        S_SMALL,
        S_CLEAR,
        S_SINGLE
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [RADIX_W-1:0] rem;
    } t_div_res;

    // font entry bytes 0..3 from msb down
    function automatic logic [31:0] font_row(input logic [7:0] idx);
        logic [31:0] row;
        case (idx)
            8'd1:    row = 32'h00482200;
            8'd2:    row = 32'h5B48BA5A;
            8'd3:    row = 32'h5A000000;
            8'd4:    row = 32'h6D009836;
            8'd5:    row = 32'h7F009800;
            8'd6:    row = 32'h7E00006C;
            8'd7:    row = 32'h0112986C;
            8'd8:    row = 32'h3700987E;
            8'd9:    row = 32'h5A008800;
            8'd10:   row = 32'h7F00987E;
            8'd11:   row = 32'h7F00986C;
            8'd12:   row = 32'h00240000;
            8'd13:   row = 32'h00242200;
            8'd14:   row = 32'h005A0000;
            8'd15:   row = 32'h25001024;
            8'd16:   row = 32'h00006600;
            8'd17:   row = 32'h6C008836;
            8'd18:   row = 32'h6D48985A;
            8'd19:   row = 32'h7E00887E;
            8'd20:   row = 32'h7F249800;
            8'd21:   row = 32'h0100985A;
            8'd22:   row = 32'h5B249800;
            8'd23:   row = 32'h2500987E;
            8'd24:   row = 32'h0000887E;
            8'd25:   row = 32'h3700985A;
            8'd26:   row = 32'h7E00007E;
            8'd27:   row = 32'h01249800;
            8'd28:   row = 32'h5B001012;
            8'd29:   row = 32'h005A007E;
            8'd30:   row = 32'h0100105A;
            8'd31:   row = 32'h5A48445A;
            8'd32:   row = 32'h5A12445A;
            8'd33:   row = 32'h5B00985A;
            8'd34:   row = 32'h6C00887E;
            8'd35:   row = 32'h5B12985A;
            8'd36:   row = 32'h6C12887E;
            8'd37:   row = 32'h3700986C;
            8'd38:   row = 32'h00248800;
            8'd39:   row = 32'h5B00105A;
            8'd40:   row = 32'h0048225A;
            8'd41:   row = 32'h5A12225A;
            8'd42:   row = 32'h005A6600;
            8'd43:   row = 32'h00486600;
            8'd44:   row = 32'h0148BA00;
            8'd45:   row = 32'h0148BA00;
            8'd46:   row = 32'h0148BA00;
            8'd47:   row = 32'h0148BA00;
            8'd48:   row = 32'h0148BA00;
            8'd49:   row = 32'h01001000;
            default: row = 32'h00000000;
        endcase
        return row;
    endfunction

    // small-number glyph, byte 0 in the upper half
    function automatic logic [15:0] digit_pair(input logic [3:0] d);
        logic [15:0] p;
        case (d)
            4'd0:    p = 16'hDB7E;
            4'd1:    p = 16'h0A60;
            4'd2:    p = 16'hBD5A;
            4'd3:    p = 16'hAF78;
            4'd4:    p = 16'h6E64;
            4'd5:    p = 16'hE73C;
            4'd6:    p = 16'hF73E;
            4'd7:    p = 16'h8A68;
            4'd8:    p = 16'hFF7E;
            4'd9:    p = 16'hEE6C;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_code(input logic [RADIX_W-1:0] d);
        logic [7:0] c;
        if (d < RADIX_W'(10)) begin
            c = CODE_ZERO + {2'b00, d};
        end else begin
            c = CODE_ALPHA + {2'b00, d};
        end
        return c;
    endfunction

    // first byte of the cell that holds a position
    function automatic logic [ADDR_W-1:0] cell_base(input logic [7:0] p);
        logic [15:0] prod;
        logic [7:0]  q6;
        logic [7:0]  r;
        prod = {8'b0, p} * CELL_RECIP;
        q6   = {2'b00, prod[15:CELL_RECIP_SH]} * 8'(CELLS);
        r    = p - q6;
        return ADDR_W'(2) + {1'b0, r[2:0], 2'b00};
    endfunction

endpackage

@@ rtl/seglcd_mem.sv @@
module seglcd_mem (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  seglcd_pkg::t_mem_req   i_req,
    output logic [7:0]             o_rdata
);

    logic [7:0]                       r_mem [seglcd_pkg::SEG_BYTES];
    logic [seglcd_pkg::SEG_BYTES-1:0] r_vld;
    logic [7:0]                       r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_vld[i_req.addr] ? r_mem[i_req.addr] : 8'h00;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/seglcd_div.sv @@
module seglcd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [seglcd_pkg::VALUE_W-1:0]      i_dividend,
    input  logic [seglcd_pkg::RADIX_W-1:0]      i_divisor,
    output seglcd_pkg::t_div_res                o_res
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [seglcd_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [seglcd_pkg::VALUE_W-1:0]       r_quo;
    logic [seglcd_pkg::RADIX_W-1:0]       r_rem;
    logic [seglcd_pkg::RADIX_W-1:0]       r_div;
    logic [seglcd_pkg::RADIX_W:0]         trial;
    logic [seglcd_pkg::RADIX_W:0]         diff;
    logic                                 fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[seglcd_pkg::VALUE_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == seglcd_pkg::DIV_CNT_W'(seglcd_pkg::VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[seglcd_pkg::VALUE_W-2:0], fits};
            r_rem <= fits ? diff[seglcd_pkg::RADIX_W-1:0] : trial[seglcd_pkg::RADIX_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

@@ rtl/segment_lcd_text_writer_unit.sv @@
// flow: a character runs a start state, then a read and a write state per cell byte in the memory
// a number first runs all its digits through the bit-serial divider, then draws them as characters
// clear writes every segment byte, a small number two bytes, and a bad radix or unknown operation
// gives one empty word; output stalls hold the block, and the next command is taken in idle
// reset: segment image reads as all zero at once (per-byte valid bits), no clearing pass;
// flash position returns to 255 and the flash counter to zero
module segment_lcd_text_writer_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // command channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_operation,
    input  logic [7:0]                             i_position,
    input  logic [7:0]                             i_character,
    input  logic [seglcd_pkg::VALUE_W-1:0]         i_value,
    input  logic [seglcd_pkg::RADIX_W-1:0]         i_radix,

    // result channel, one word per segment byte write, plus empty words for bytes past the memory and rejected commands
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_write_enable,
    output logic [seglcd_pkg::ADDR_W-1:0]          o_segment_address,
    output logic [7:0]                             o_segment_data,
    output logic [7:0]                             o_end_position,
    output logic                                   o_bad_radix,
    output logic                                   o_last,

    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [seglcd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    seglcd_pkg::t_state r_state, n_state;

    // latched command
    logic [2:0]                              r_op, n_op;
    logic [7:0]                              r_pos, n_pos;
    logic [7:0]                              r_char, n_char;
    logic [seglcd_pkg::VALUE_W-1:0]          r_value, n_value;
    logic [seglcd_pkg::VALUE_W-1:0]          r_num, n_num;
    logic [seglcd_pkg::RADIX_W-1:0]          r_divisor, n_divisor;

    // digit buffer, filled least significant first
    logic [seglcd_pkg::RADIX_W-1:0]          r_dig [seglcd_pkg::DIG_DEPTH];
    logic [seglcd_pkg::DIG_CNT_W-1:0]        r_ndig, n_ndig;
    logic [seglcd_pkg::DIG_CNT_W-1:0]        r_di, n_di;
    logic                                    dig_we;

    // fixed point fraction walk
    logic [seglcd_pkg::FRAC_W-1:0]           r_fi, n_fi;
    logic                                    r_frac_ph, n_frac_ph;
    logic [7:0]                              r_frac, n_frac;

    // current character cell
    logic [1:0]                              r_k, n_k;
    logic [seglcd_pkg::ADDR_W-1:0]           r_clr, n_clr;
    logic [seglcd_pkg::ADDR_W-1:0]           r_base, n_base;
    logic                                    r_upper, n_upper;
    logic [31:0]                             r_glyph, n_glyph;

    logic [7:0]                              r_end, n_end;
    logic                                    r_bad, n_bad;
    logic [7:0]                              r_flash_pos, n_flash_pos;
    logic [7:0]                              r_flash_cnt, n_flash_cnt;

    // output register
    logic                                    r_ovalid;
    logic                                    r_owe;
    logic [seglcd_pkg::ADDR_W-1:0]           r_oaddr;
    logic [7:0]                              r_odata;
    logic                                    r_olast;
    logic [7:0]                              r_oend;
    logic                                    r_obad;

    logic                                    emit;
    logic                                    e_we;
    logic [seglcd_pkg::ADDR_W-1:0]           e_addr;
    logic [7:0]                              e_data;
    logic                                    e_last;

    seglcd_pkg::t_mem_req                    mem_req;
    logic [7:0]                              mem_rdata;
    logic                                    div_start;
    seglcd_pkg::t_div_res                    div_res;

    logic                                    can_emit;
    logic                                    cfg_wr;
    logic                                    last_digit;
    logic                                    frac_last;
    logic                                    char_last;
    logic [seglcd_pkg::ADDR_W-1:0]           byte_addr;
    logic                                    byte_in_range;
    logic [7:0]                              glyph_byte;
    logic [7:0]                              merged;
    logic [11:0]                             frac_prod;
    logic [7:0]                              sel_pos;
    logic [7:0]                              sel_code;
    logic                                    flash_hit;
    logic [7:0]                              shown_code;
    logic [6:0]                              small_n;
    logic [14:0]                             tens_prod;
    logic [3:0]                              tens;
    logic [6:0]                              ones_w;
    logic [15:0]                             pair_t;
    logic [15:0]                             pair_o;
    logic [7:0]                              small_byte;
    seglcd_pkg::t_state                      adv_state;

    seglcd_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    seglcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (r_divisor),
        .o_res      (div_res)
    );

    // the output register frees when empty or when its word is taken this cycle
    assign can_emit = !r_ovalid || !i_out_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == seglcd_pkg::REG_FLASH);
    assign prdata = (paddr[2] == seglcd_pkg::REG_FLASH) ? {24'b0, r_flash_pos} : 32'b0;

    // where a character job sits in its command
    assign last_digit = (r_di == r_ndig - 1'b1);
    assign frac_last  = (r_fi == seglcd_pkg::FRAC_W'(seglcd_pkg::FRAC_DIGITS - 1));
    assign char_last  = (r_op == seglcd_pkg::OP_CHAR)
                     || (r_op == seglcd_pkg::OP_NUMBER && last_digit)
                     || (r_op == seglcd_pkg::OP_FIXED && r_frac_ph && frac_last);

    // cell byte k takes font byte 3-k, which sits at bits 8k+7:8k
    assign byte_addr     = r_base + {4'b0, r_k};
    assign byte_in_range = byte_addr < seglcd_pkg::ADDR_W'(seglcd_pkg::SEG_BYTES);
    assign glyph_byte    = 8'(r_glyph >> {r_k, 3'b000});
    assign merged        = r_upper ? {glyph_byte[7:4], mem_rdata[3:0]}
                                   : {mem_rdata[7:4], glyph_byte[3:0]};

    // next fraction digit: f = (f & 0xff) * 10, digit is f >> 8
    assign frac_prod = {4'b0, r_frac} * 12'd10;

    // character to place next, chosen by command and phase
    always_comb begin
        if (r_op == seglcd_pkg::OP_CHAR) begin
            sel_pos  = r_pos;
            sel_code = r_char;
        end else if (r_op == seglcd_pkg::OP_FIXED && r_frac_ph) begin
            sel_pos  = seglcd_pkg::FIXED_FRAC_POS + {6'b0, r_fi};
            sel_code = seglcd_pkg::CODE_ZERO + {4'b0, frac_prod[11:8]};
        end else begin
            sel_pos  = ((r_op == seglcd_pkg::OP_FIXED) ? seglcd_pkg::FIXED_INT_POS : r_pos)
                     - {3'b0, r_di};
            sel_code = seglcd_pkg::digit_code(r_dig[r_di[seglcd_pkg::DIG_IDX_W-1:0]]);
        end
    end

    // cursor blinks as underscore while counter bit 2 is set
    assign flash_hit  = (sel_pos == r_flash_pos);
    assign shown_code = (flash_hit && r_flash_cnt[seglcd_pkg::FLASH_BIT])
                      ? seglcd_pkg::CODE_UNDERLINE : sel_code;

    // small number, saturated at 99, split into tens and ones
    assign small_n   = (r_value > seglcd_pkg::VALUE_W'(seglcd_pkg::SMALL_MAX))
                     ? seglcd_pkg::SMALL_MAX : r_value[6:0];
    assign tens_prod = {8'b0, small_n} * seglcd_pkg::TEN_RECIP;
    assign tens      = tens_prod[14:seglcd_pkg::TEN_RECIP_SH];
    assign ones_w    = small_n - ({3'b0, tens} * 7'd10);
    assign pair_t    = seglcd_pkg::digit_pair(tens);
    assign pair_o    = seglcd_pkg::digit_pair(ones_w[3:0]);
    assign small_byte = r_k[0] ? {pair_o[7:4], pair_t[3:0]} : {pair_o[15:12], pair_t[11:8]};

    // where to go once a cell byte is done
    always_comb begin
        if (r_k != 2'd3) begin
            adv_state = seglcd_pkg::S_CHAR_RD;
        end else begin
            case (r_op)
                seglcd_pkg::OP_NUMBER: begin
                    adv_state = last_digit ? seglcd_pkg::S_IDLE : seglcd_pkg::S_CHAR_START;
                end
                seglcd_pkg::OP_FIXED: begin
                    if (r_frac_ph) begin
                        adv_state = frac_last ? seglcd_pkg::S_IDLE : seglcd_pkg::S_CHAR_START;
                    end else begin
                        adv_state = last_digit ? seglcd_pkg::S_DOT_RD
                                               : seglcd_pkg::S_CHAR_START;
                    end
                end
                default: begin
                    adv_state = seglcd_pkg::S_IDLE;
                end
            endcase
        end
    end

    // sequencer: next state, memory and divider requests, result words
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_char      = r_char;
        n_value     = r_value;
        n_num       = r_num;
        n_divisor   = r_divisor;
        n_ndig      = r_ndig;
        n_di        = r_di;
        n_fi        = r_fi;
        n_frac_ph   = r_frac_ph;
        n_frac      = r_frac;
        n_k         = r_k;
        n_clr       = r_clr;
        n_base      = r_base;
        n_upper     = r_upper;
        n_glyph     = r_glyph;
        n_end       = r_end;
        n_bad       = r_bad;
        n_flash_cnt = r_flash_cnt;
        n_flash_pos = cfg_wr ? pwdata[7:0] : r_flash_pos;
        mem_req     = '0;
        div_start   = 1'b0;
        dig_we      = 1'b0;
        emit        = 1'b0;
        e_we        = 1'b0;
        e_addr      = '0;
        e_data      = 8'h00;
        e_last      = 1'b0;
        o_in_stall  = 1'b1;

        case (r_state)
            seglcd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_pos     = i_position;
                    n_char    = i_character;
                    n_value   = i_value;
                    n_ndig    = '0;
                    n_di      = '0;
                    n_fi      = '0;
                    n_frac_ph = 1'b0;
                    n_frac    = i_value[7:0];
                    n_k       = '0;
                    n_clr     = '0;
                    n_end     = 8'h00;
                    n_bad     = (i_operation == seglcd_pkg::OP_NUMBER)
                             && (i_radix < seglcd_pkg::RADIX_W'(2));
                    if (i_operation == seglcd_pkg::OP_FIXED) begin
                        n_num     = {8'b0, i_value[15:8]};
                        n_divisor = seglcd_pkg::RADIX_W'(10);
                    end else begin
                        n_num     = i_value;
                        n_divisor = i_radix;
                    end
                    case (i_operation)
                        seglcd_pkg::OP_CHAR: begin
                            n_state = seglcd_pkg::S_CHAR_START;
                        end
                        seglcd_pkg::OP_NUMBER: begin
                            n_state = (i_radix < seglcd_pkg::RADIX_W'(2))
                                    ? seglcd_pkg::S_SINGLE : seglcd_pkg::S_DIV_GO;
                        end
                        seglcd_pkg::OP_FIXED: begin
                            n_state = seglcd_pkg::S_DIV_GO;
                        end
                        seglcd_pkg::OP_SMALL: begin
                            n_state = seglcd_pkg::S_SMALL;
                        end
                        seglcd_pkg::OP_CLEAR: begin
                            n_state = seglcd_pkg::S_CLEAR;
                        end
                        default: begin
                            n_state = seglcd_pkg::S_SINGLE;
                        end
                    endcase
                end
            end

            seglcd_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = seglcd_pkg::S_DIV_WAIT;
            end

            seglcd_pkg::S_DIV_WAIT: begin
                if (div_res.done) begin
                    dig_we = 1'b1;
                    n_ndig = r_ndig + 1'b1;
                    if (div_res.quot == '0) begin
                        n_state = seglcd_pkg::S_CHAR_START;
                        n_di    = '0;
                        if (r_op == seglcd_pkg::OP_NUMBER) begin
                            n_end = (r_value == '0) ? r_pos : r_pos - {3'b0, n_ndig};
                        end
                    end else begin
                        n_num   = div_res.quot;
                        n_state = seglcd_pkg::S_DIV_GO;
                    end
                end
            end

            seglcd_pkg::S_CHAR_START: begin
                if (flash_hit) begin
                    n_flash_cnt = r_flash_cnt + 1'b1;
                end
                if (r_op == seglcd_pkg::OP_FIXED && r_frac_ph) begin
                    n_frac = frac_prod[7:0];
                end
                n_glyph = seglcd_pkg::font_row(shown_code - seglcd_pkg::FONT_BASE);
                n_upper = sel_pos >= 8'(seglcd_pkg::CELLS);
                n_base  = seglcd_pkg::cell_base(sel_pos);
                n_k     = '0;
                n_state = seglcd_pkg::S_CHAR_RD;
            end

            seglcd_pkg::S_CHAR_RD: begin
                if (byte_in_range) begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = byte_addr;
                    n_state       = seglcd_pkg::S_CHAR_WR;
                end else if (can_emit) begin
                    // cell byte past the memory: empty word
                    emit    = 1'b1;
                    e_last  = char_last && (r_k == 2'd3);
                    n_k     = r_k + 1'b1;
                    n_state = adv_state;
                    if (r_k == 2'd3) begin
                        if (r_op == seglcd_pkg::OP_FIXED && r_frac_ph) begin
                            n_fi = r_fi + 1'b1;
                        end else begin
                            n_di = r_di + 1'b1;
                        end
                    end
                end
            end

            seglcd_pkg::S_CHAR_WR: begin
                if (can_emit) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = byte_addr;
                    mem_req.wdata = merged;
                    emit    = 1'b1;
                    e_we    = 1'b1;
                    e_addr  = byte_addr;
                    e_data  = merged;
                    e_last  = char_last && (r_k == 2'd3);
                    n_k     = r_k + 1'b1;
                    n_state = adv_state;
                    if (r_k == 2'd3) begin
                        if (r_op == seglcd_pkg::OP_FIXED && r_frac_ph) begin
                            n_fi = r_fi + 1'b1;
                        end else begin
                            n_di = r_di + 1'b1;
                        end
                    end
                end
            end

            seglcd_pkg::S_DOT_RD: begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = seglcd_pkg::DOT_BYTE;
                n_state       = seglcd_pkg::S_DOT_WR;
            end

            seglcd_pkg::S_DOT_WR: begin
                if (can_emit) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = seglcd_pkg::DOT_BYTE;
                    mem_req.wdata = mem_rdata | seglcd_pkg::DOT_MASK;
                    emit      = 1'b1;
                    e_we      = 1'b1;
                    e_addr    = seglcd_pkg::DOT_BYTE;
                    e_data    = mem_rdata | seglcd_pkg::DOT_MASK;
                    n_frac_ph = 1'b1;
                    n_fi      = '0;
                    n_state   = seglcd_pkg::S_CHAR_START;
                end
            end

            seglcd_pkg::S_SMALL: begin
                if (can_emit) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = seglcd_pkg::ADDR_W'(r_k);
                    mem_req.wdata = small_byte;
                    emit   = 1'b1;
                    e_we   = 1'b1;
                    e_addr = seglcd_pkg::ADDR_W'(r_k);
                    e_data = small_byte;
                    e_last = r_k[0];
                    n_k    = r_k + 1'b1;
                    if (r_k[0]) begin
                        n_state = seglcd_pkg::S_IDLE;
                    end
                end
            end

            seglcd_pkg::S_CLEAR: begin
                if (can_emit) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = r_clr;
                    mem_req.wdata = 8'h00;
                    emit   = 1'b1;
                    e_we   = 1'b1;
                    e_addr = r_clr;
                    e_last = (r_clr == seglcd_pkg::ADDR_W'(seglcd_pkg::SEG_BYTES - 1));
                    n_clr  = r_clr + 1'b1;
                    if (e_last) begin
                        n_state = seglcd_pkg::S_IDLE;
                    end
                end
            end

            seglcd_pkg::S_SINGLE: begin
                // bad radix or unknown operation: one empty closing word
                if (can_emit) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = seglcd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = seglcd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= seglcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_pos <= seglcd_pkg::FLASH_NONE;
            r_flash_cnt <= 8'h00;
            r_ovalid    <= 1'b0;
        end else begin
            r_flash_pos <= n_flash_pos;
            r_flash_cnt <= n_flash_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_char    <= n_char;
        r_value   <= n_value;
        r_num     <= n_num;
        r_divisor <= n_divisor;
        r_ndig    <= n_ndig;
        r_di      <= n_di;
        r_fi      <= n_fi;
        r_frac_ph <= n_frac_ph;
        r_frac    <= n_frac;
        r_k       <= n_k;
        r_clr     <= n_clr;
        r_base    <= n_base;
        r_upper   <= n_upper;
        r_glyph   <= n_glyph;
        r_end     <= n_end;
        r_bad     <= n_bad;
        if (dig_we) begin
            r_dig[r_ndig[seglcd_pkg::DIG_IDX_W-1:0]] <= div_res.rem;
        end
        if (emit) begin
            r_owe   <= e_we;
            r_oaddr <= e_addr;
            r_odata <= e_data;
            r_olast <= e_last;
            r_oend  <= n_end;
            r_obad  <= r_bad;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_write_enable    = r_owe;
    assign o_segment_address = r_oaddr;
    assign o_segment_data    = r_odata;
    assign o_end_position    = r_oend;
    assign o_bad_radix       = r_obad;
    assign o_last            = r_olast;

`ifndef SYNTHESIS
    // a byte write stays inside the segment image
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_enable)
        |-> (o_segment_address < seglcd_pkg::ADDR_W'(seglcd_pkg::SEG_BYTES)))
        else $error("segment write beyond memory");

    // a bad radix gives a single empty closing word
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_radix) |-> (o_last && !o_write_enable))
        else $error("bad radix word malformed");

    // every memory write is reported as a word
    a_write_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (emit && e_we))
        else $error("memory write without result word");

    // digit buffer never overflows
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == seglcd_pkg::S_DIV_WAIT)
        |-> (r_ndig < seglcd_pkg::DIG_CNT_W'(seglcd_pkg::DIG_DEPTH)))
        else $error("digit buffer overflow");
`endif

endmodule

@@ tb/sv/tb_segment_lcd_text_writer_unit.sv @@
`timescale 1ns / 1ps

module tb_segment_lcd_text_writer_unit;

    // one command word
    typedef struct packed {
        logic [2:0]                     op;
        logic [7:0]                     pos;
        logic [7:0]                     code;
        logic [seglcd_pkg::VALUE_W-1:0] value;
        logic [seglcd_pkg::RADIX_W-1:0] radix;
    } t_cmd;

    // one expected segment write word
    typedef struct packed {
        logic                          we;
        logic [seglcd_pkg::ADDR_W-1:0] addr;
        logic [7:0]                    data;
        logic [7:0]                    end_pos;
        logic                          bad;
        logic                          last;
    } t_seg_write;

    localparam logic [2:0] OP_UNKNOWN = 3'd5;
    localparam int         LIMIT      = 5000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_operation = '0;
    logic [7:0] i_position = '0;
    logic [7:0] i_character = '0;
    logic [seglcd_pkg::VALUE_W-1:0] i_value = '0;
    logic [seglcd_pkg::RADIX_W-1:0] i_radix = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_write_enable;
    logic [seglcd_pkg::ADDR_W-1:0] o_segment_address;
    logic [7:0] o_segment_data;
    logic [7:0] o_end_position;
    logic o_bad_radix;
    logic o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [seglcd_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    segment_lcd_text_writer_unit uut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0] seg_image [seglcd_pkg::SEG_BYTES];
    logic [7:0] blink_count;
    logic [7:0] blink_pos;

    t_cmd       cmd_queue [$];
    t_seg_write write_queue [$];
    int         errors = 0;
    int         cycles = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         hold_input = 1'b0;
    bit         stim_done = 1'b0;

    t_seg_write pend [$];

    // font entry as four bytes, byte 0 in the top
    function automatic logic [31:0] glyph_bytes(input int idx);
        logic [31:0] g [50] = '{
            32'h0, 32'h00482200, 32'h5B48BA5A, 32'h5A000000, 32'h6D009836,
            32'h7F009800, 32'h7E00006C, 32'h0112986C, 32'h3700987E, 32'h5A008800,
            32'h7F00987E, 32'h7F00986C, 32'h00240000, 32'h00242200, 32'h005A0000,
            32'h25001024, 32'h00006600, 32'h6C008836, 32'h6D48985A, 32'h7E00887E,
            32'h7F249800, 32'h0100985A, 32'h5B249800, 32'h2500987E, 32'h0000887E,
            32'h3700985A, 32'h7E00007E, 32'h01249800, 32'h5B001012, 32'h005A007E,
            32'h0100105A, 32'h5A48445A, 32'h5A12445A, 32'h5B00985A, 32'h6C00887E,
            32'h5B12985A, 32'h6C12887E, 32'h3700986C, 32'h00248800, 32'h5B00105A,
            32'h0048225A, 32'h5A12225A, 32'h005A6600, 32'h00486600, 32'h0148BA00,
            32'h0148BA00, 32'h0148BA00, 32'h0148BA00, 32'h0148BA00, 32'h01001000};
        return g[idx];
    endfunction

    function automatic logic [15:0] small_glyph(input int d);
        logic [15:0] g [10] = '{16'hDB7E, 16'h0A60, 16'hBD5A, 16'hAF78, 16'h6E64,
                                16'hE73C, 16'hF73E, 16'h8A68, 16'hFF7E, 16'hEE6C};
        return g[d];
    endfunction

    function automatic void push_byte(input int addr, input logic [7:0] data);
        t_seg_write w;
        w = '0;
        if (addr < seglcd_pkg::SEG_BYTES) begin
            seg_image[addr] = data;
            w.we = 1'b1;
            w.addr = seglcd_pkg::ADDR_W'(addr);
            w.data = data;
        end
        pend.push_back(w);
    endfunction

    function automatic void draw_char(input logic [7:0] pos, input logic [7:0] code);
        logic [7:0]  idx;
        logic [31:0] g;
        logic [7:0]  f;
        int          base;
        bit          upper;
        upper = pos >= seglcd_pkg::CELLS;
        if (pos == blink_pos) begin
            if (blink_count[seglcd_pkg::FLASH_BIT]) code = seglcd_pkg::CODE_UNDERLINE;
            blink_count = blink_count + 8'd1;
        end
        idx = code - seglcd_pkg::FONT_BASE;
        if (idx >= 8'd50) idx = 8'd0;
        g = glyph_bytes(idx);
        base = 2 + (pos % seglcd_pkg::CELLS) * 4;
        for (int k = 0; k < 4; k++) begin
            // cell byte k takes font byte 3-k, which is the lowest byte for k = 0
            f = g[8*k +: 8];
            if (base + k < seglcd_pkg::SEG_BYTES)
                push_byte(base + k, upper ? ((seg_image[base+k] & 8'h0F) | (f & 8'hF0))
                                          : ((seg_image[base+k] & 8'hF0) | (f & 8'h0F)));
            else
                push_byte(seglcd_pkg::SEG_BYTES, 8'h00);
        end
    endfunction

    function automatic logic [7:0] draw_number(input int num, input logic [7:0] pos,
                                               input int radix);
        int d;
        if (num == 0) begin
            draw_char(pos, seglcd_pkg::CODE_ZERO);
            return pos;
        end
        while (num > 0) begin
            d = num % radix;
            draw_char(pos, d < 10 ? 8'(48 + d) : 8'(55 + d));
            pos = pos - 8'd1;
            num = num / radix;
        end
        return pos;
    endfunction

    // expected segment writes of one command
    function automatic void predict_writes(input t_cmd c);
        logic [7:0] end_pos;
        bit         bad;
        int         f, n;
        logic [15:0] a, b;
        end_pos = '0;
        bad = 1'b0;
        pend.delete();
        case (c.op)
            seglcd_pkg::OP_CHAR: draw_char(c.pos, c.code);
            seglcd_pkg::OP_NUMBER: begin
                if (c.radix < 2) begin
                    bad = 1'b1;
                    push_byte(seglcd_pkg::SEG_BYTES, 8'h00);
                end else begin
                    end_pos = draw_number(c.value, c.pos, c.radix);
                end
            end
            seglcd_pkg::OP_FIXED: begin
                f = c.value;
                void'(draw_number(c.value >> 8, seglcd_pkg::FIXED_INT_POS, 10));
                push_byte(seglcd_pkg::DOT_BYTE,
                          seg_image[seglcd_pkg::DOT_BYTE] | seglcd_pkg::DOT_MASK);
                for (int i = 0; i < seglcd_pkg::FRAC_DIGITS; i++) begin
                    f = (f & 'hFF) * 10;
                    draw_char(8'(3 + i), 8'(48 + (f >> 8)));
                end
            end
            seglcd_pkg::OP_SMALL: begin
                n = c.value > 99 ? 99 : c.value;
                a = small_glyph(n / 10);
                b = small_glyph(n % 10);
                push_byte(0, (a[15:8] & 8'h0F) | (b[15:8] & 8'hF0));
                push_byte(1, (a[7:0] & 8'h0F) | (b[7:0] & 8'hF0));
            end
            seglcd_pkg::OP_CLEAR:
                for (int i = 0; i < seglcd_pkg::SEG_BYTES; i++) push_byte(i, 8'h00);
            default: push_byte(seglcd_pkg::SEG_BYTES, 8'h00);
        endcase
        for (int i = 0; i < pend.size(); i++) begin
            pend[i].end_pos = end_pos;
            pend[i].bad = bad;
            pend[i].last = (i == pend.size() - 1);
            write_queue.push_back(pend[i]);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: valid held until accepted, payload stable while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_writes(cmd_queue.pop_front());
                in_gap = pick_gap();
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (in_gap > 0 || hold_input || cmd_queue.size() == 0
                        || (i_in_valid && !o_in_stall && cmd_queue.size() == 0)) begin
                    i_in_valid <= 1'b0;
                    if (in_gap > 0) in_gap = in_gap - 1;
                end else begin
                    i_in_valid  <= 1'b1;
                    i_operation <= cmd_queue[0].op;
                    i_position  <= cmd_queue[0].pos;
                    i_character <= cmd_queue[0].code;
                    i_value     <= cmd_queue[0].value;
                    i_radix     <= cmd_queue[0].radix;
                end
            end
        end
    end

    // monitor and random stall on the result side
    always @(posedge i_clk) begin
        t_seg_write exp_w, got;
        cycles = cycles + 1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_write_enable, o_segment_address, o_segment_data,
                        o_end_position, o_bad_radix, o_last};
                if (write_queue.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, got);
                    errors = errors + 1;
                end else begin
                    exp_w = write_queue.pop_front();
                    if (got !== exp_w) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
                        errors = errors + 1;
                    end
                end
            end
            if (out_gap > 0) begin
                i_out_stall <= 1'b1;
                out_gap = out_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] op, input logic [7:0] pos, input logic [7:0] code,
                           input logic [15:0] value, input logic [5:0] radix);
        t_cmd c;
        c.op    = op;
        c.pos   = pos;
        c.code  = code;
        c.value = value;
        c.radix = radix;
        cmd_queue.push_back(c);
    endtask

    task automatic drain();
        wait (cmd_queue.size() == 0 && !i_in_valid);
        wait (write_queue.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_blink_pos(input logic [7:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {24'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        blink_pos = v;
    endtask

    task automatic add_random_cmd();
        int r;
        logic [7:0] pos;
        r = $urandom_range(0, 99);
        // positions mostly near the cells, some anywhere
        pos = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 13));
        if (r < 40)
            add_cmd(seglcd_pkg::OP_CHAR, pos, ($urandom_range(0, 2) == 0) ? 8'($urandom)
                    : 8'($urandom_range(32, 96)), 16'($urandom), 6'($urandom));
        else if (r < 62)
            add_cmd(seglcd_pkg::OP_NUMBER, pos, 8'($urandom),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 999)) : 16'($urandom),
                    ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(2, 36)));
        else if (r < 77)
            add_cmd(seglcd_pkg::OP_FIXED, pos, 8'($urandom), 16'($urandom), 6'($urandom));
        else if (r < 92)
            add_cmd(seglcd_pkg::OP_SMALL, pos, 8'($urandom),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 120)) : 16'($urandom),
                    6'($urandom));
        else if (r < 96)
            add_cmd(seglcd_pkg::OP_CLEAR, pos, 8'($urandom), 16'($urandom), 6'($urandom));
        else
            add_cmd(3'($urandom_range(OP_UNKNOWN, 7)), pos, 8'($urandom), 16'($urandom),
                    6'($urandom));
    endtask

    initial begin
        for (int i = 0; i < seglcd_pkg::SEG_BYTES; i++) seg_image[i] = '0;
        blink_count = '0;
        blink_pos = seglcd_pkg::FLASH_NONE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every operation, font edges, row split, radix extremes
        add_cmd(seglcd_pkg::OP_CHAR, 8'd0, 8'd48, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_CHAR, 8'd5, 8'd95, 16'hFFFF, 6'h3F);
        add_cmd(seglcd_pkg::OP_CHAR, 8'd6, 8'd46, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_CHAR, 8'd11, 8'd32, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_CHAR, 8'd255, 8'd255, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_CHAR, 8'd7, 8'd96, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd5, 8'd0, 16'd0, 6'd10);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd11, 8'd0, 16'hFFFF, 6'd2);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd1, 8'd0, 16'hFFFF, 6'd36);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd3, 8'd0, 16'd12345, 6'd0);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd3, 8'd0, 16'd7, 6'd1);
        add_cmd(seglcd_pkg::OP_NUMBER, 8'd4, 8'd0, 16'd4000, 6'h3F);
        add_cmd(seglcd_pkg::OP_FIXED, 8'd200, 8'd0, 16'hFFFF, 6'd0);
        add_cmd(seglcd_pkg::OP_FIXED, 8'd0, 8'd0, 16'h0000, 6'd0);
        add_cmd(seglcd_pkg::OP_SMALL, 8'd0, 8'd0, 16'd0, 6'd0);
        add_cmd(seglcd_pkg::OP_SMALL, 8'd0, 8'd0, 16'd99, 6'd0);
        add_cmd(seglcd_pkg::OP_SMALL, 8'd0, 8'd0, 16'hFFFF, 6'd0);
        add_cmd(OP_UNKNOWN, 8'd0, 8'd0, 16'd0, 6'd0);
        add_cmd(3'd7, 8'hFF, 8'hFF, 16'hFFFF, 6'h3F);
        add_cmd(seglcd_pkg::OP_CLEAR, 8'd0, 8'd0, 16'd0, 6'd0);
        drain();

        // blink on a lower and an upper position, then the extremes
        write_blink_pos(8'd2);
        for (int i = 0; i < 20; i++) add_cmd(seglcd_pkg::OP_CHAR, 8'd2, 8'd65, 16'd0, 6'd0);
        drain();
        write_blink_pos(8'd0);
        for (int i = 0; i < 80; i++) add_random_cmd();
        // sender waits mid-stream for every word once
        wait (cmd_queue.size() <= 40);
        hold_input = 1'b1;
        wait (write_queue.size() == 0 && !i_in_valid);
        hold_input = 1'b0;
        drain();
        write_blink_pos(8'd9);
        for (int i = 0; i < 120; i++) add_random_cmd();
        drain();
        write_blink_pos(8'd255);
        for (int i = 0; i < 110; i++) add_random_cmd();
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
